>>> rtl/core/lmcs_pkg.sv
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared constants, types and tables for the LED matrix column scan block.
// ----------------------------------------------------------------------------
package lmcs_pkg;

  localparam int ROWS          = 6;
  localparam int COLS          = 16;
  localparam int BRIGHT_LEVELS = 4;

  localparam int PIX_W   = 8;
  localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DITH_W  = (BRIGHT_LEVELS > 1) ? $clog2(BRIGHT_LEVELS) : 1;
  localparam int LVL_W   = 2;
  localparam int SPD_W   = 2;
  localparam int CMP_W   = (DITH_W > LVL_W) ? DITH_W : LVL_W;
  localparam int WORD_W  = ROWS * PIX_W;
  localparam int PHASE_W = 8;

  localparam int OUT_COL_W = 4;
  localparam int MASK_W    = 6;
  localparam int OUT_ROW_W = 3;
  localparam int RES_W     = OUT_COL_W + MASK_W + OUT_ROW_W + OUT_COL_W + PHASE_W;
  localparam int M_DATA_W  = ((RES_W + 7) / 8) * 8;

  localparam int NUM_REGS = 3;
  localparam int APB_AW   = $clog2(4 * NUM_REGS);
  localparam int APB_DW   = 32;

  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [APB_AW-3:0] {
    REG_DISPLAY_ON = 2'd0,
    REG_BRIGHTNESS = 2'd1,
    REG_SPEED      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic               lit_en;
    logic               eff_valid;
    logic [PIX_W-1:0]   eff_value;
    logic [ROW_W-1:0]   fill_row;
    logic               wrap;
    logic [ROW_W-1:0]   req_row;
    logic [COL_W-1:0]   req_col;
    logic [PHASE_W-1:0] req_phase;
  } scan_req_t;

  typedef struct packed {
    logic [PHASE_W-1:0]   request_phase;
    logic [OUT_COL_W-1:0] request_col;
    logic [OUT_ROW_W-1:0] request_row;
    logic                 frame_wrap;
    logic [MASK_W-1:0]    anode_mask;
    logic [OUT_COL_W-1:0] scan_column;
  } scan_res_t;

  function automatic logic [PHASE_W-1:0] speed_step(input logic [SPD_W-1:0] sel);
    logic [PHASE_W-1:0] step;
    case (sel)
      2'd0:    step = PHASE_W'(1);
      2'd1:    step = PHASE_W'(2);
      2'd2:    step = PHASE_W'(4);
      default: step = PHASE_W'(8);
    endcase
    return step;
  endfunction

endpackage

>>> rtl/core/lmcs_ram.sv
// ----------------------------------------------------------------------------
// lmcs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lmcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/lmcs_scan_ctrl.sv
// ----------------------------------------------------------------------------
// lmcs_scan_ctrl
// Register file, scan and fill counters, and column read issue.
// ----------------------------------------------------------------------------
module lmcs_scan_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [lmcs_pkg::APB_AW-1:0]   paddr_i,
  input  logic [lmcs_pkg::APB_DW-1:0]   pwdata_i,
  output logic [lmcs_pkg::APB_DW-1:0]   prdata_o,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic                          s_user_i,
  input  logic [lmcs_pkg::PIX_W-1:0]    s_data_i,
  input  logic [lmcs_pkg::CNT_W-1:0]    fifo_cnt_i,
  output lmcs_pkg::ram_rd_t             rd_o,
  output lmcs_pkg::scan_req_t           req_o,
  output logic                          req_vld_o
);
  import lmcs_pkg::*;

  logic               display_on_q;
  logic [LVL_W-1:0]   level_q;
  logic [SPD_W-1:0]   speed_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [DITH_W-1:0]  dith_q, dith_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               col_last, row_last, dith_last;
  logic               cfg_wr, accept, run;
  cfg_reg_e           reg_idx;
  scan_req_t          req_q, req_d;
  logic               req_vld_q;

  assign reg_idx = cfg_reg_e'(paddr_i[APB_AW-1:2]);
  assign cfg_wr  = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_on_q <= 1'b1;
      level_q      <= LVL_W'(3);
      speed_q      <= SPD_W'(2);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DISPLAY_ON: display_on_q <= pwdata_i[0];
        REG_BRIGHTNESS: level_q      <= pwdata_i[LVL_W-1:0];
        REG_SPEED:      speed_q      <= pwdata_i[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DISPLAY_ON: prdata_o = APB_DW'(display_on_q);
      REG_BRIGHTNESS: prdata_o = APB_DW'(level_q);
      REG_SPEED:      prdata_o = APB_DW'(speed_q);
      default:        prdata_o = '0;
    endcase
  end

  // credit check: words in the queue plus the one in flight
  assign s_ready_o = ((CNT_W+1)'(fifo_cnt_i) + (CNT_W+1)'(req_vld_q))
                     < (CNT_W+1)'(FIFO_DEPTH);
  assign accept    = s_valid_i & s_ready_o;
  assign run       = accept & display_on_q;

  // the fill column always equals the scan column, so one counter serves both
  always_comb begin
    col_last  = (col_q == COL_W'(COLS - 1));
    row_last  = (row_q == ROW_W'(ROWS - 1));
    dith_last = (dith_q == DITH_W'(BRIGHT_LEVELS - 1));
    col_d     = col_last ? '0 : col_q + COL_W'(1);
    row_d     = row_q;
    dith_d    = dith_q;
    phase_d   = phase_q;
    if (col_last) begin
      row_d  = row_last ? '0 : row_q + ROW_W'(1);
      dith_d = dith_last ? '0 : dith_q + DITH_W'(1);
      if (row_last) begin
        phase_d = phase_q + speed_step(speed_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      dith_q    <= '0;
      phase_q   <= '0;
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= run;
      if (run) begin
        col_q   <= col_d;
        row_q   <= row_d;
        dith_q  <= dith_d;
        phase_q <= phase_d;
      end
    end
  end

  always_comb begin
    req_d.col       = col_q;
    req_d.lit_en    = (CMP_W'(dith_q) <= CMP_W'(level_q));
    req_d.eff_valid = s_user_i;
    req_d.eff_value = s_data_i;
    req_d.fill_row  = row_q;
    req_d.wrap      = col_last;
    req_d.req_row   = row_d;
    req_d.req_col   = col_d;
    req_d.req_phase = phase_d;
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      req_q <= req_d;
    end
  end

  assign rd_o.en   = run;
  assign rd_o.addr = col_q;
  assign req_o     = req_q;
  assign req_vld_o = req_vld_q;

endmodule

>>> rtl/core/lmcs_pixel_path.sv
// ----------------------------------------------------------------------------
// lmcs_pixel_path
// Column word read-modify-write, anode decode, store valid bits and forwarding.
// ----------------------------------------------------------------------------
module lmcs_pixel_path (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lmcs_pkg::ram_rd_t            rd_i,
  input  lmcs_pkg::scan_req_t          req_i,
  input  logic                         req_vld_i,
  input  logic [lmcs_pkg::WORD_W-1:0]  rdata_i,
  output lmcs_pkg::ram_wr_t            wr_o,
  output lmcs_pkg::scan_res_t          res_o,
  output logic                         res_vld_o
);
  import lmcs_pkg::*;

  logic [COLS-1:0]   col_vld_q;
  logic              hit_q, rd_vld_q;
  logic [WORD_W-1:0] fwd_q;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] merged;
  logic [ROWS-1:0]   anodes;
  logic              hit_d;

  assign hit_d = rd_i.en & wr_o.en & (rd_i.addr == wr_o.addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q <= '0;
      hit_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      hit_q    <= hit_d;
      rd_vld_q <= col_vld_q[rd_i.addr];
      if (wr_o.en) begin
        col_vld_q[wr_o.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= wr_o.data;
  end

  // unwritten columns read as dark
  assign base = hit_q ? fwd_q : (rd_vld_q ? rdata_i : '0);

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      anodes[r] = req_i.lit_en & base[r*PIX_W + PIX_W - 1];
      merged[r*PIX_W +: PIX_W] = (req_i.eff_valid && (req_i.fill_row == ROW_W'(r)))
                                 ? req_i.eff_value : base[r*PIX_W +: PIX_W];
    end
  end

  assign wr_o.en   = req_vld_i & req_i.eff_valid;
  assign wr_o.addr = req_i.col;
  assign wr_o.data = merged;

  always_comb begin
    res_o.scan_column   = OUT_COL_W'(req_i.col);
    res_o.anode_mask    = MASK_W'(anodes);
    res_o.frame_wrap    = req_i.wrap;
    res_o.request_row   = OUT_ROW_W'(req_i.req_row);
    res_o.request_col   = OUT_COL_W'(req_i.req_col);
    res_o.request_phase = req_i.req_phase;
  end

  assign res_vld_o = req_vld_i;

endmodule

>>> rtl/core/lmcs_out_fifo.sv
// ----------------------------------------------------------------------------
// lmcs_out_fifo
// Small result queue decoupling the pixel path from output backpressure.
// ----------------------------------------------------------------------------
module lmcs_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  lmcs_pkg::scan_res_t          data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output lmcs_pkg::scan_res_t          data_o,
  output logic [lmcs_pkg::CNT_W-1:0]   cnt_o
);
  import lmcs_pkg::*;

  scan_res_t          entry_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & ready_i;
  assign data_o  = entry_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/led_matrix_column_scan_dither.sv
// ----------------------------------------------------------------------------
// led_matrix_column_scan_dither
// Column-multiplexed LED matrix scan with brightness dither and effect fill.
//
//   channel  | direction | fields
//   ---------+-----------+------------------------------------------------
//   s_axis   | in        | tuser: effect_valid; tdata: effect_value
//   m_axis   | out       | tdata: scan_column, anode_mask, request_row,
//            |           |        request_col, request_phase; tlast: frame_wrap
//   apb      | in        | display_on, brightness_level, speed_select
//
// One tick is accepted per cycle while s_axis_tready is high; its word passes
// the request register and the output queue before it can be taken. Throughput
// is set by the one column-wide pixel RAM port pair: read, write on effect_valid.
// Reset clears counters and column valid bits at once; no clearing pass.
// A three-word output queue absorbs stalls; tready drops once queued words
// plus the one in flight reach three.
// ----------------------------------------------------------------------------
module led_matrix_column_scan_dither (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lmcs_pkg::APB_AW-1:0]   paddr,
  input  logic [lmcs_pkg::APB_DW-1:0]   pwdata,
  output logic [lmcs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lmcs_pkg::PIX_W-1:0]    s_axis_tdata,  // [7:0] effect_value
  input  logic [0:0]                    s_axis_tuser,  // [0] effect_valid
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] scan_column, [9:4] anode_mask, [12:10] request_row,
  // [16:13] request_col, [24:17] request_phase, rest zero
  output logic [lmcs_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast   // frame_wrap
);
  import lmcs_pkg::*;

  ram_rd_t           rd;
  ram_wr_t           wr;
  scan_req_t         req;
  logic              req_vld;
  logic [WORD_W-1:0] rdata;
  scan_res_t         res, out_res;
  logic              res_vld;
  logic [CNT_W-1:0]  fifo_cnt;

  assign pready = 1'b1;

  lmcs_scan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_user_i   (s_axis_tuser[0]),
    .s_data_i   (s_axis_tdata),
    .fifo_cnt_i (fifo_cnt),
    .rd_o       (rd),
    .req_o      (req),
    .req_vld_o  (req_vld)
  );

  lmcs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (COLS)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.en),
    .raddr_i (rd.addr),
    .rdata_o (rdata)
  );

  lmcs_pixel_path u_path (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .req_i     (req),
    .req_vld_i (req_vld),
    .rdata_i   (rdata),
    .wr_o      (wr),
    .res_o     (res),
    .res_vld_o (res_vld)
  );

  lmcs_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_vld),
    .data_i  (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res),
    .cnt_o   (fifo_cnt)
  );

  assign m_axis_tdata = M_DATA_W'({out_res.request_phase, out_res.request_col,
                                   out_res.request_row, out_res.anode_mask,
                                   out_res.scan_column});
  assign m_axis_tlast = out_res.frame_wrap;

endmodule

>>> dv/tb_led_matrix_column_scan_dither.sv
// ----------------------------------------------------------------------------
// tb_led_matrix_column_scan_dither
// Self-checking bench for the LED matrix column scan block. Scan ticks go in
// on the slave stream and each output word is compared with a cycle-free
// scan predictor that keeps its own pixel store, counters and registers.
// Both stream sides idle at random. The registers are swept through their
// extremes over the APB port, with the display switched off and on again.
// ----------------------------------------------------------------------------
module tb_led_matrix_column_scan_dither;
  timeunit 1ns;
  timeprecision 1ps;

  import lmcs_pkg::*;

  localparam int          SETTLE_CYCLES = 8;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          MAX_REPORTS   = 10;
  localparam int          PHASE_TICKS   = 160;
  localparam logic [1:0]  REG_SPARE     = 2'd3;
  localparam logic [7:0]  LIT_LEVEL     = 8'h80;

  typedef struct packed {
    logic [OUT_COL_W-1:0] column;
    logic [MASK_W-1:0]    anodes;
    logic                 wrap;
    logic [OUT_ROW_W-1:0] req_row;
    logic [OUT_COL_W-1:0] req_col;
    logic [PHASE_W-1:0]   req_phase;
  } scan_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;  // [7:0] effect_value
  logic [0:0]            s_axis_tuser;  // [0] effect_valid
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [3:0] scan_column, [9:4] anode_mask, [12:10] request_row,
  // [16:13] request_col, [24:17] request_phase
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;  // frame_wrap

  // scan predictor state
  logic [PIX_W-1:0]      pixel_mem [ROWS*COLS];
  int                    col_ctr;
  int                    dither_ctr;
  int                    fill_r;
  int                    fill_c;
  logic [PHASE_W-1:0]    phase_acc;
  logic                  disp_on;
  logic [LVL_W-1:0]      bright_lvl;
  logic [SPD_W-1:0]      speed_sel;
  scan_word_t            pending_words[$];

  bit                    tx_idle;
  bit                    rx_idle;
  int                    error_count;
  int                    ticks_sent;
  int                    words_checked;
  int                    reg_writes;
  int                    reg_reads;
  int                    cycle_count;

  led_matrix_column_scan_dither u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("led_matrix_column_scan_dither test failed");
      $finish;
    end
  end

  function automatic logic [APB_DW-1:0] reg_value(input logic [1:0] idx);
    logic [APB_DW-1:0] val;
    case (idx)
      REG_DISPLAY_ON: val = APB_DW'(disp_on);
      REG_BRIGHTNESS: val = APB_DW'(bright_lvl);
      REG_SPEED:      val = APB_DW'(speed_sel);
      default:        val = '0;
    endcase
    return val;
  endfunction

  function automatic logic [PIX_W-1:0] pick_value();
    logic [PIX_W-1:0] val;
    case ($urandom_range(0, 9))
      0:       val = 8'h00;
      1:       val = 8'h7f;
      2:       val = 8'h80;
      3:       val = 8'hff;
      default: val = PIX_W'($urandom);
    endcase
    return val;
  endfunction

  task automatic predict_tick(input logic valid, input logic [PIX_W-1:0] value);
    scan_word_t w;
    int r;
    if (!disp_on) return;
    w = '0;
    w.column = OUT_COL_W'(col_ctr);
    if (dither_ctr <= int'(bright_lvl)) begin
      for (r = 0; r < ROWS; r++) begin
        if (pixel_mem[r*COLS + col_ctr] >= LIT_LEVEL) w.anodes[r] = 1'b1;
      end
    end
    if (valid) pixel_mem[fill_r*COLS + fill_c] = value;
    fill_c++;
    if (fill_c >= COLS) begin
      fill_c = 0;
      fill_r++;
      if (fill_r >= ROWS) begin
        fill_r = 0;
        phase_acc = phase_acc + (PHASE_W'(1) << speed_sel);
      end
    end
    col_ctr++;
    if (col_ctr >= COLS) begin
      col_ctr = 0;
      w.wrap = 1'b1;
      dither_ctr = (dither_ctr + 1) % BRIGHT_LEVELS;
    end
    w.req_row   = OUT_ROW_W'(fill_r);
    w.req_col   = OUT_COL_W'(fill_c);
    w.req_phase = phase_acc;
    pending_words.push_back(w);
  endtask

  // output word checker
  always @(posedge clk_i) begin : word_check
    scan_word_t want;
    scan_word_t got;
    logic       pad_bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.column    = m_axis_tdata[3:0];
      got.anodes    = m_axis_tdata[9:4];
      got.req_row   = m_axis_tdata[12:10];
      got.req_col   = m_axis_tdata[16:13];
      got.req_phase = m_axis_tdata[24:17];
      got.wrap      = m_axis_tlast;
      pad_bad       = |m_axis_tdata[M_DATA_W-1:RES_W];
      if (pending_words.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected word %h tlast %b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_words.pop_front();
        if (got !== want || pad_bad) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("word %0d expected col %0d mask %b wrap %b req r%0d c%0d ph %0d",
                     words_checked, want.column, want.anodes, want.wrap,
                     want.req_row, want.req_col, want.req_phase);
            $display("word %0d actual   col %0d mask %b wrap %b req r%0d c%0d ph %0d pad %b",
                     words_checked, got.column, got.anodes, got.wrap,
                     got.req_row, got.req_col, got.req_phase, pad_bad);
          end
        end
      end
      words_checked++;
    end
  end

  // receiver back-pressure
  initial begin : word_sink
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // all tasks below start and end on a falling edge
  task automatic send_tick(input logic valid, input logic [PIX_W-1:0] value);
    int gap;
    s_axis_tuser  <= valid;
    s_axis_tdata  <= value;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tick(valid, value);
    ticks_sent++;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] keep;
    keep = (idx == REG_DISPLAY_ON) ? APB_DW'(1) : APB_DW'(3);
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= (APB_DW'($urandom) & ~keep) | (value & keep);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_DISPLAY_ON: disp_on    = value[0];
      REG_BRIGHTNESS: bright_lvl = value[LVL_W-1:0];
      REG_SPEED:      speed_sel  = value[SPD_W-1:0];
      default:        ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= APB_AW'({idx, 2'b00});
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== reg_value(idx)) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("register %0d read expected %h actual %h", idx, reg_value(idx), prdata);
    end
    reg_reads++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_register_access();
    check_reg(REG_DISPLAY_ON);
    check_reg(REG_BRIGHTNESS);
    check_reg(REG_SPEED);
    write_reg(REG_DISPLAY_ON, 0);
    check_reg(REG_DISPLAY_ON);
    write_reg(REG_DISPLAY_ON, 1);
    check_reg(REG_DISPLAY_ON);
    write_reg(REG_BRIGHTNESS, 0);
    check_reg(REG_BRIGHTNESS);
    write_reg(REG_SPEED, 3);
    check_reg(REG_SPEED);
    write_reg(REG_SPEED, 0);
    check_reg(REG_SPEED);
    // unmapped index must leave the others alone
    write_reg(REG_SPARE, $urandom);
    check_reg(REG_DISPLAY_ON);
    check_reg(REG_BRIGHTNESS);
    check_reg(REG_SPEED);
    write_reg(REG_BRIGHTNESS, 3);
    write_reg(REG_SPEED, 2);
  endtask

  task automatic test_directed_ticks();
    logic [PIX_W-1:0] pattern [7];
    int i;
    pattern = '{8'hff, 8'h80, 8'h7f, 8'h00, 8'hff, 8'h81, 8'h01};
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (i = 0; i < 24; i++) send_tick((i % 5) != 4, pattern[i % 7]);
    wait_idle();
  endtask

  task automatic test_display_off();
    int i;
    write_reg(REG_DISPLAY_ON, 0);
    check_reg(REG_DISPLAY_ON);
    for (i = 0; i < 12; i++) send_tick($urandom_range(0, 1) != 0, pick_value());
    write_reg(REG_DISPLAY_ON, 1);
    for (i = 0; i < 24; i++) send_tick($urandom_range(0, 5) != 0, pick_value());
    wait_idle();
  endtask

  task automatic test_random_configs();
    logic [LVL_W-1:0] lvl [6];
    logic [SPD_W-1:0] spd [6];
    int p;
    int i;
    lvl = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, LVL_W'($urandom)};
    spd = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, SPD_W'($urandom)};
    for (p = 0; p < 6; p++) begin
      write_reg(REG_BRIGHTNESS, APB_DW'(lvl[p]));
      write_reg(REG_SPEED, APB_DW'(spd[p]));
      tx_idle = (p != 2);
      rx_idle = (p != 2);
      for (i = 0; i < PHASE_TICKS; i++) begin
        // sender holds off until the pipe is empty
        if (p == 1 && i == PHASE_TICKS / 2) wait_idle();
        send_tick($urandom_range(0, 6) != 0, pick_value());
      end
      wait_idle();
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    error_count   = 0;
    ticks_sent    = 0;
    words_checked = 0;
    reg_writes    = 0;
    reg_reads     = 0;
    cycle_count   = 0;
    foreach (pixel_mem[k]) pixel_mem[k] = '0;
    col_ctr       = 0;
    dither_ctr    = 0;
    fill_r        = 0;
    fill_c        = 0;
    phase_acc     = '0;
    disp_on       = 1'b1;
    bright_lvl    = 2'd3;
    speed_sel     = 2'd2;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_register_access();
    test_directed_ticks();
    test_display_off();
    test_random_configs();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (pending_words.size() != 0) error_count++;
    $display("sent %0d scan ticks, checked %0d output words", ticks_sent, words_checked);
    $display("%0d register writes, %0d register reads, %0d mismatches",
             reg_writes, reg_reads, error_count);
    if (error_count == 0) begin
      $display("led_matrix_column_scan_dither test passed");
    end else begin
      $display("led_matrix_column_scan_dither test failed");
    end
    $finish;
  end

endmodule
